FILE: design/pse_pkg.sv
// ---------------------------------------------------------------------------
// pse_pkg: shared definitions for the postfix stack evaluator
// Stack geometry, number format, symbol codes, status codes, the cell shift
// code and saturating 64-bit arithmetic.
// ---------------------------------------------------------------------------
package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int VAL_W       = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] SYM_DIGIT_LO = 8'd48;
    localparam logic [7:0] SYM_DIGIT_HI = 8'd57;
    localparam logic [7:0] SYM_TRIPLE   = 8'h68;
    localparam logic [7:0] SYM_ADD      = 8'h2B;
    localparam logic [7:0] SYM_SUB      = 8'h2D;
    localparam logic [7:0] SYM_F        = 8'h66;
    localparam logic [7:0] SYM_G        = 8'h67;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_NOT_ONE   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // What every stack cell does in a cycle.
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_DOWN = 2'd1,
        SH_UP1  = 2'd2,
        SH_UP2  = 2'd3
    } t_shift;

    typedef struct packed {
        logic start;
        logic is_f;
    } t_fg_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_fg_rsp;

    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] r;
        r = a + b;
        if ((a[VAL_W-1] == b[VAL_W-1]) && (r[VAL_W-1] != a[VAL_W-1])) begin
            r = a[VAL_W-1] ? VAL_MIN : VAL_MAX;
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] r;
        r = a - b;
        if ((a[VAL_W-1] != b[VAL_W-1]) && (r[VAL_W-1] != a[VAL_W-1])) begin
            r = a[VAL_W-1] ? VAL_MIN : VAL_MAX;
        end
        return r;
    endfunction

endpackage

FILE: design/pse_cell.sv
// ---------------------------------------------------------------------------
// pse_cell: one entry of the operand stack
// Holds one value and moves it toward or away from the top together with
// its neighbors.
// ---------------------------------------------------------------------------
module pse_cell (
    input  logic                  i_clk,
    input  pse_pkg::t_shift       i_shift,
    input  logic [pse_pkg::VAL_W-1:0] i_above,
    input  logic [pse_pkg::VAL_W-1:0] i_below1,
    input  logic [pse_pkg::VAL_W-1:0] i_below2,
    output logic [pse_pkg::VAL_W-1:0] o_value
);
    import pse_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    always_comb begin
        case (i_shift)
            SH_DOWN: n_value = i_above;
            SH_UP1:  n_value = i_below1;
            SH_UP2:  n_value = i_below2;
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: design/pse_fg_unit.sv
// ---------------------------------------------------------------------------
// pse_fg_unit: multi-cycle unit for the three-operand operators
// Computes a*a - b/2 + c or a*b + c with a fixed-point product built from
// four 32x32 partial products, one per cycle, and saturation at each step.
// ---------------------------------------------------------------------------
module pse_fg_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pse_pkg::t_fg_req          i_req,
    input  logic [pse_pkg::VAL_W-1:0] i_a,
    input  logic [pse_pkg::VAL_W-1:0] i_b,
    input  logic [pse_pkg::VAL_W-1:0] i_c,
    output pse_pkg::t_fg_rsp          o_rsp,
    output logic [pse_pkg::VAL_W-1:0] o_value
);
    import pse_pkg::*;

    localparam int HALF_W = VAL_W / 2;
    localparam int PROD_W = 2 * VAL_W;
    localparam int Q_W    = PROD_W - FRAC_BITS + 1;

    typedef enum logic [6:0] {
        FG_IDLE = 7'b0000001,
        FG_MUL  = 7'b0000010,
        FG_RND  = 7'b0000100,
        FG_SAT  = 7'b0001000,
        FG_SUB  = 7'b0010000,
        FG_ADD  = 7'b0100000,
        FG_DONE = 7'b1000000
    } t_fg_state;

    t_fg_state r_state, n_state;
    logic [2:0] r_k, n_k;

    logic [VAL_W-1:0]  r_ma, r_mb, r_half, r_c, r_v;
    logic              r_neg;
    logic [VAL_W-1:0]  r_pp;
    logic [1:0]        r_pp_sh;
    logic [PROD_W-1:0] r_acc;
    logic [Q_W-1:0]    r_q;

    logic [HALF_W-1:0] w_x, w_y;
    logic [PROD_W-1:0] w_pp_shifted;
    logic [VAL_W-1:0]  w_abs_a, w_abs_b, w_sat_prod;
    logic              w_round;

    assign w_abs_a = i_a[VAL_W-1] ? (VAL_W'(0) - i_a) : i_a;
    assign w_abs_b = i_b[VAL_W-1] ? (VAL_W'(0) - i_b) : i_b;

    assign w_x = r_k[1] ? r_ma[VAL_W-1:HALF_W] : r_ma[HALF_W-1:0];
    assign w_y = r_k[0] ? r_mb[VAL_W-1:HALF_W] : r_mb[HALF_W-1:0];

    always_comb begin
        case (r_pp_sh)
            2'd1:    w_pp_shifted = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            2'd2:    w_pp_shifted = {r_pp, {VAL_W{1'b0}}};
            default: w_pp_shifted = {{VAL_W{1'b0}}, r_pp};
        endcase
    end

    assign w_round = r_neg && (|r_acc[FRAC_BITS-1:0]);

    // The magnitude quotient saturates at 2^63-1 when positive and 2^63 when
    // negative, the latter giving the most negative value.
    always_comb begin
        if (!r_neg) begin
            w_sat_prod = (|r_q[Q_W-1:VAL_W-1]) ? VAL_MAX : r_q[VAL_W-1:0];
        end else if ((|r_q[Q_W-1:VAL_W]) || (r_q[VAL_W-1] && (|r_q[VAL_W-2:0]))) begin
            w_sat_prod = VAL_MIN;
        end else begin
            w_sat_prod = VAL_W'(0) - r_q[VAL_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            FG_IDLE: begin
                if (i_req.start) begin
                    n_state = FG_MUL;
                    n_k     = 3'd0;
                end
            end
            FG_MUL: begin
                n_k = r_k + 3'd1;
                if (r_k == 3'd4) begin
                    n_state = FG_RND;
                end
            end
            FG_RND:  n_state = FG_SAT;
            FG_SAT:  n_state = FG_SUB;
            FG_SUB:  n_state = FG_ADD;
            FG_ADD:  n_state = FG_DONE;
            FG_DONE: n_state = FG_IDLE;
            default: n_state = FG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FG_IDLE;
            r_k     <= 3'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FG_IDLE: begin
                if (i_req.start) begin
                    r_ma   <= w_abs_a;
                    r_mb   <= i_req.is_f ? w_abs_a : w_abs_b;
                    r_neg  <= i_req.is_f ? 1'b0 : (i_a[VAL_W-1] ^ i_b[VAL_W-1]);
                    r_half <= i_req.is_f ? {i_b[VAL_W-1], i_b[VAL_W-1:1]} : '0;
                    r_c    <= i_c;
                    r_acc  <= '0;
                end
            end
            FG_MUL: begin
                if (r_k != 3'd0) begin
                    r_acc <= r_acc + w_pp_shifted;
                end
                if (r_k != 3'd4) begin
                    r_pp    <= VAL_W'(w_x * w_y);
                    r_pp_sh <= 2'(r_k[0]) + 2'(r_k[1]);
                end
            end
            FG_RND: r_q <= Q_W'(r_acc[PROD_W-1:FRAC_BITS]) + Q_W'(w_round);
            FG_SAT: r_v <= w_sat_prod;
            FG_SUB: r_v <= sat_sub(r_v, r_half);
            FG_ADD: r_v <= sat_add(r_v, r_c);
            default: ;
        endcase
    end

    assign o_rsp.busy = (r_state != FG_IDLE);
    assign o_rsp.done = (r_state == FG_DONE);
    assign o_value    = r_v;

endmodule

FILE: design/postfix_stack_evaluator_unit.sv
// ---------------------------------------------------------------------------
// postfix_stack_evaluator_unit: postfix expression evaluator
// Evaluates a character stream in fixed point on a stack built as a row of
// shifting cells, and emits the value and a status on the last character.
// ---------------------------------------------------------------------------
//   channel  | direction | tdata            | tuser      | tlast
//   s_axis   | in        | [7:0] symbol     | -          | end_of_expression
//   m_axis   | out       | [63:0] result    | [1:0] status | -
//
// Digits, 'h', '+', '-' and ignored characters are applied to the stack when
// accepted; the top of the stack sits in the first cell, so these never wait
// on a memory. 'f' and 'g' hold off further input while the four-step partial
// product multiply and the rounding and saturation steps after it run.
// Reset clears the count, the error and the output valid; cell contents and the output value are kept.
// A held result stalls input only when a new result would have to replace it.
// ---------------------------------------------------------------------------
module postfix_stack_evaluator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] result_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import pse_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_err, n_err;
    logic             r_pend_last, n_pend_last;
    logic             r_m_valid, n_m_valid;
    logic [VAL_W-1:0] r_m_value, n_m_value;
    t_status          r_m_status, n_m_status;

    logic [VAL_W-1:0] w_cell [STACK_DEPTH];
    t_shift           w_shift, w_top_shift;
    logic [VAL_W-1:0] w_new_top, w_top_next, w_fg_value, w_triple, w_digit;
    t_fg_req          w_fg_req;
    t_fg_rsp          w_fg_rsp;
    logic             w_in_acc, w_finish;
    t_status          w_fin_err;

    function automatic logic [VAL_W-1:0] sat_triple(input logic [VAL_W-1:0] a);
        logic [VAL_W+1:0] ext;
        logic [VAL_W+1:0] t;
        ext = {{2{a[VAL_W-1]}}, a};
        t   = ext + {ext[VAL_W:0], 1'b0};
        if ((t[VAL_W+1] == t[VAL_W]) && (t[VAL_W] == t[VAL_W-1])) begin
            return t[VAL_W-1:0];
        end
        return t[VAL_W+1] ? VAL_MIN : VAL_MAX;
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [VAL_W-1:0] w_above, w_below1, w_below2;
            t_shift           w_sh;
            if (gi == 0) begin : g_top
                assign w_above = w_new_top;
                assign w_sh    = w_top_shift;
            end else begin : g_mid
                assign w_above = w_cell[gi-1];
                assign w_sh    = w_shift;
            end
            if (gi + 1 < STACK_DEPTH) begin : g_b1
                assign w_below1 = w_cell[gi+1];
            end else begin : g_b1z
                assign w_below1 = '0;
            end
            if (gi + 2 < STACK_DEPTH) begin : g_b2
                assign w_below2 = w_cell[gi+2];
            end else begin : g_b2z
                assign w_below2 = '0;
            end
            pse_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_sh),
                .i_above  (w_above),
                .i_below1 (w_below1),
                .i_below2 (w_below2),
                .o_value  (w_cell[gi])
            );
        end
    endgenerate

    pse_fg_unit u_fg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_fg_req),
        .i_a     (w_cell[2]),
        .i_b     (w_cell[1]),
        .i_c     (w_cell[0]),
        .o_rsp   (w_fg_rsp),
        .o_value (w_fg_value)
    );

    // Only a request that closes an expression needs a free output register.
    assign s_axis_tready = !w_fg_rsp.busy &&
                           (!s_axis_tlast || !r_m_valid || m_axis_tready);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_triple      = sat_triple(w_cell[0]);
    assign w_digit       = VAL_W'(s_axis_tdata - SYM_DIGIT_LO) << FRAC_BITS;

    always_comb begin
        n_count     = r_count;
        n_err       = r_err;
        n_pend_last = r_pend_last;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_value   = r_m_value;
        n_m_status  = r_m_status;
        w_shift     = SH_HOLD;
        w_top_shift = SH_HOLD;
        w_new_top   = w_digit;
        w_fg_req    = '0;
        w_finish    = 1'b0;
        w_fin_err   = ST_OK;
        w_top_next  = w_cell[0];

        if (w_fg_rsp.done) begin
            w_top_shift = SH_DOWN;
            w_shift     = SH_UP2;
            w_new_top   = w_fg_value;
            n_count     = r_count - CNT_W'(2);
            w_finish    = r_pend_last;
            n_pend_last = 1'b0;
        end else if (w_in_acc) begin
            if (r_err == ST_OK) begin
                case (s_axis_tdata) inside
                    [SYM_DIGIT_LO:SYM_DIGIT_HI]: begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            n_err = ST_OVERFLOW;
                        end else begin
                            w_top_shift = SH_DOWN;
                            w_shift     = SH_DOWN;
                            n_count     = r_count + CNT_W'(1);
                        end
                    end
                    SYM_TRIPLE: begin
                        if (r_count < CNT_W'(1)) begin
                            n_err = ST_UNDERFLOW;
                        end else begin
                            w_top_shift = SH_DOWN;
                            w_new_top   = w_triple;
                        end
                    end
                    SYM_ADD, SYM_SUB: begin
                        if (r_count < CNT_W'(2)) begin
                            n_err = ST_UNDERFLOW;
                        end else begin
                            w_top_shift = SH_DOWN;
                            w_shift     = SH_UP1;
                            w_new_top   = (s_axis_tdata == SYM_ADD) ?
                                          sat_add(w_cell[1], w_cell[0]) :
                                          sat_sub(w_cell[1], w_cell[0]);
                            n_count     = r_count - CNT_W'(1);
                        end
                    end
                    SYM_F, SYM_G: begin
                        if (r_count < CNT_W'(3)) begin
                            n_err = ST_UNDERFLOW;
                        end else begin
                            w_fg_req.start = 1'b1;
                            w_fg_req.is_f  = (s_axis_tdata == SYM_F);
                        end
                    end
                    default: ;
                endcase
            end
            // A three-operand operator closes the expression when it finishes.
            if (w_fg_req.start) begin
                n_pend_last = s_axis_tlast;
            end else begin
                w_finish = s_axis_tlast;
            end
        end

        if (w_top_shift == SH_DOWN) begin
            w_top_next = w_new_top;
        end

        if (w_finish) begin
            w_fin_err  = ((n_err == ST_OK) && (n_count != CNT_W'(1))) ? ST_NOT_ONE : n_err;
            n_m_valid  = 1'b1;
            n_m_status = w_fin_err;
            n_m_value  = (w_fin_err == ST_OK) ? w_top_next : '0;
            n_count    = '0;
            n_err      = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_pend_last <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_err       <= n_err;
            r_pend_last <= n_pend_last;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_value  <= n_m_value;
        r_m_status <= n_m_status;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_value;
    assign m_axis_tuser  = r_m_status;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench for postfix_stack_evaluator_unit
// Sends postfix expressions one symbol per request, predicts each result in
// a scoreboard with its own operand stack and saturating fixed-point math,
// and checks value and status of every result in order. Directed cases come
// first: each operator, saturation, every error kind and ignored symbols.
// Random well-formed, broken and noise expressions follow, under sender
// bursts and receiver stall patterns.
// ---------------------------------------------------------------------------
module tb;
    import pse_pkg::*;

    class expr_scoreboard;

        typedef struct {
            logic [VAL_W-1:0] value;
            t_status          status;
        } t_eval_result;

        logic [VAL_W-1:0] operand_stack [STACK_DEPTH];
        int unsigned      stack_fill;
        t_status          pending_err;
        t_eval_result     expected_results [$];
        int unsigned      failures;
        int unsigned      results_checked;
        int unsigned      status_seen [4];

        function new();
            stack_fill  = 0;
            pending_err = ST_OK;
            failures    = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function logic [VAL_W-1:0] sat_sum(input logic [VAL_W-1:0] a,
                                           input logic [VAL_W-1:0] b);
            logic signed [VAL_W:0] s;
            s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
            // The two top bits differ only when the 64-bit range was left.
            if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
            return s[VAL_W-1:0];
        endfunction

        function logic [VAL_W-1:0] sat_diff(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
            logic signed [VAL_W:0] s;
            s = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
            if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
            return s[VAL_W-1:0];
        endfunction

        function logic [VAL_W-1:0] fix_mul(input logic [VAL_W-1:0] a,
                                           input logic [VAL_W-1:0] b);
            logic signed [2*VAL_W-1:0] p;
            logic signed [2*VAL_W-1:0] q;
            logic signed [2*VAL_W-1:0] hi_lim;
            logic signed [2*VAL_W-1:0] lo_lim;
            hi_lim = $signed({{VAL_W{1'b0}}, VAL_MAX});
            lo_lim = $signed({{VAL_W{1'b1}}, VAL_MIN});
            p = $signed({{VAL_W{a[VAL_W-1]}}, a}) * $signed({{VAL_W{b[VAL_W-1]}}, b});
            // Arithmetic shift of the full product rounds toward minus infinity.
            q = p >>> FRAC_BITS;
            if (q > hi_lim) return VAL_MAX;
            if (q < lo_lim) return VAL_MIN;
            return q[VAL_W-1:0];
        endfunction

        function logic [VAL_W-1:0] half_down(input logic [VAL_W-1:0] b);
            return {b[VAL_W-1], b[VAL_W-1:1]};
        endfunction

        function void push_operand(input logic [VAL_W-1:0] v);
            if (stack_fill >= STACK_DEPTH) begin
                pending_err = ST_OVERFLOW;
                return;
            end
            operand_stack[stack_fill] = v;
            stack_fill++;
        endfunction

        function bit enough(input int unsigned n);
            if (stack_fill < n) begin
                pending_err = ST_UNDERFLOW;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void apply_symbol(input logic [7:0] sym);
            logic [VAL_W-1:0] a;
            logic [VAL_W-1:0] b;
            logic [VAL_W-1:0] c;
            logic [VAL_W-1:0] v;
            if (sym >= SYM_DIGIT_LO && sym <= SYM_DIGIT_HI) begin
                v = VAL_W'(sym - SYM_DIGIT_LO);
                push_operand(v << FRAC_BITS);
            end else if (sym == SYM_TRIPLE) begin
                if (enough(1)) begin
                    a = operand_stack[stack_fill-1];
                    operand_stack[stack_fill-1] = sat_sum(sat_sum(a, a), a);
                end
            end else if (sym == SYM_ADD || sym == SYM_SUB) begin
                if (enough(2)) begin
                    b = operand_stack[stack_fill-1];
                    a = operand_stack[stack_fill-2];
                    stack_fill -= 2;
                    push_operand(sym == SYM_ADD ? sat_sum(a, b) : sat_diff(a, b));
                end
            end else if (sym == SYM_F || sym == SYM_G) begin
                if (enough(3)) begin
                    c = operand_stack[stack_fill-1];
                    b = operand_stack[stack_fill-2];
                    a = operand_stack[stack_fill-3];
                    stack_fill -= 3;
                    if (sym == SYM_F) begin
                        push_operand(sat_sum(sat_diff(fix_mul(a, a), half_down(b)), c));
                    end else begin
                        push_operand(sat_sum(fix_mul(a, b), c));
                    end
                end
            end
        endfunction

        // Called for every accepted input request.
        function void note_symbol(input logic [7:0] sym, input logic last);
            t_eval_result r;
            if (pending_err == ST_OK) apply_symbol(sym);
            if (last) begin
                if (pending_err == ST_OK && stack_fill != 1) pending_err = ST_NOT_ONE;
                r.value  = (pending_err == ST_OK) ? operand_stack[0] : '0;
                r.status = pending_err;
                expected_results.push_back(r);
                stack_fill  = 0;
                pending_err = ST_OK;
            end
        endfunction

        // Called for every accepted output request.
        function void check_result(input logic [VAL_W-1:0] value,
                                   input logic [1:0] status);
            t_eval_result r;
            if (expected_results.size() == 0) begin
                $error("unexpected result: result_value %0d, status %0d",
                       $signed(value), status);
                failures++;
                return;
            end
            r = expected_results.pop_front();
            results_checked++;
            status_seen[r.status]++;
            if (status !== r.status) begin
                $error("status mismatch: expected %0d, actual %0d", r.status, status);
                failures++;
            end
            if (value !== r.value) begin
                $error("result_value mismatch: expected %0d, actual %0d",
                       $signed(r.value), $signed(value));
                failures++;
            end
        endfunction

    endclass

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 430;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] symbol
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // [63:0] result_value
    logic [1:0]  m_axis_tuser;          // [1:0] status

    expr_scoreboard sb = new();

    logic [7:0]  expr_q [$];
    int unsigned burst_left  = 0;
    int unsigned sent_count  = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left  = 0;
    int unsigned sink_phase  = 0;
    t_sink_mode  sink_mode   = SINK_OPEN;

    postfix_stack_evaluator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit is_code(input logic [7:0] c);
        return (c >= SYM_DIGIT_LO && c <= SYM_DIGIT_HI) || c == SYM_TRIPLE ||
               c == SYM_ADD || c == SYM_SUB || c == SYM_F || c == SYM_G;
    endfunction

    function automatic logic [7:0] ignored_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_code(c));
        return c;
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(SYM_DIGIT_LO + $urandom_range(0, 9));
    endfunction

    // Sender: bursts of requests with random gaps between them.
    task automatic send_symbol(input logic [7:0] sym, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_symbol(sym, last);
        sent_count++;
    endtask

    // Sends the queued expression with the last flag on its final symbol.
    task automatic send_expr();
        foreach (expr_q[i]) send_symbol(expr_q[i], i == expr_q.size() - 1);
        expr_q.delete();
    endtask

    task automatic add_text(input string t);
        foreach (t[i]) expr_q.push_back(t[i]);
    endtask

    task automatic add_run(input logic [7:0] sym, input int unsigned n);
        repeat (n) expr_q.push_back(sym);
    endtask

    // A nine tripled this often is far beyond the positive range.
    task automatic add_huge();
        expr_q.push_back(SYM_DIGIT_HI);
        add_run(SYM_TRIPLE, 30);
    endtask

    task automatic build_valid_expr();
        int unsigned fill;
        int unsigned r;
        fill = 0;
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(40, STACK_DEPTH)) begin
                expr_q.push_back(random_digit());
                fill++;
            end
        end
        repeat ($urandom_range(1, 14)) begin
            r = $urandom_range(0, 99);
            if ((fill == 0 || r < 40) && fill < STACK_DEPTH) begin
                expr_q.push_back(random_digit());
                fill++;
            end else if (r < 52) begin
                if ($urandom_range(0, 9) == 0) add_run(SYM_TRIPLE, $urandom_range(5, 30));
                else expr_q.push_back(SYM_TRIPLE);
            end else if (r < 60) begin
                expr_q.push_back(ignored_char());
            end else if (r < 78 && fill >= 3) begin
                expr_q.push_back($urandom_range(0, 1) ? SYM_F : SYM_G);
                fill -= 2;
            end else if (fill >= 2) begin
                expr_q.push_back($urandom_range(0, 1) ? SYM_ADD : SYM_SUB);
                fill--;
            end else if (fill < STACK_DEPTH) begin
                expr_q.push_back(random_digit());
                fill++;
            end else begin
                expr_q.push_back(SYM_TRIPLE);
            end
        end
        // Fold the stack down to a single value.
        while (fill > 1) begin
            if (fill >= 3 && $urandom_range(0, 1)) begin
                expr_q.push_back($urandom_range(0, 1) ? SYM_F : SYM_G);
                fill -= 2;
            end else begin
                expr_q.push_back($urandom_range(0, 1) ? SYM_ADD : SYM_SUB);
                fill--;
            end
        end
        if ($urandom_range(0, 7) == 0) expr_q.push_back(ignored_char());
    endtask

    task automatic build_broken_expr();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 5))
                0, 1: expr_q.push_back(random_digit());
                2:    expr_q.push_back(SYM_TRIPLE);
                3:    expr_q.push_back($urandom_range(0, 1) ? SYM_ADD : SYM_SUB);
                4:    expr_q.push_back($urandom_range(0, 1) ? SYM_F : SYM_G);
                default: expr_q.push_back(ignored_char());
            endcase
        end
    endtask

    // Receiver: checks results and stalls on a pattern of its own.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
        if (stall_left == 0) begin
            sink_mode  = t_sink_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(50, 400);
        end else begin
            stall_left--;
        end
        sink_phase++;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_OPEN:   m_axis_tready <= 1'b1;
                SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
                default:     m_axis_tready <= sink_phase[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned random_start;
        int unsigned pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Each operator on small operands, including halving a negative odd value.
        add_text("0");      send_expr();
        add_text("9");      send_expr();
        add_text("12+");    send_expr();
        add_text("59-");    send_expr();
        add_text("7h");     send_expr();
        add_text("234f");   send_expr();
        add_text("234g");   send_expr();
        add_text("203-1f"); send_expr();
        add_text("03-52g"); send_expr();
        // Ignored symbols at both byte extremes, the last flag on one of them.
        expr_q.push_back(8'h00);
        expr_q.push_back(SYM_DIGIT_LO + 8'd3);
        expr_q.push_back(8'hFF);
        send_expr();
        // Too few operands, count not one, and a sticky first error.
        add_text("+");   send_expr();
        add_text("h");   send_expr();
        add_text("12f"); send_expr();
        add_text("12");  send_expr();
        add_text("x");   send_expr();
        add_text("+1");  send_expr();
        // Push onto a full stack, then a clean expression right after it.
        add_run(SYM_DIGIT_HI, STACK_DEPTH + 1); send_expr();
        add_text("1");   send_expr();
        // Saturation of sums at the top and of products at both ends, and large differences.
        add_huge(); add_huge(); add_text("+"); send_expr();
        add_text("0"); add_huge(); add_text("-"); send_expr();
        add_huge(); add_huge(); add_text("0g"); send_expr();
        add_huge(); add_text("00f"); send_expr();
        add_text("0"); add_huge(); add_text("-90g"); send_expr();
        add_text("0"); add_huge(); add_text("-0"); add_huge(); add_text("+f");
        send_expr();

        random_start = sent_count;
        while (sent_count < random_start + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                build_valid_expr();
                send_expr();
            end else if (pick < 92) begin
                build_broken_expr();
                send_expr();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
        end
        // Close any expression left open by the noise.
        send_symbol(SYM_DIGIT_LO, 1'b1);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.failures += sb.pending();

        $display("Sent %0d symbols and checked %0d expression results.",
                 sent_count, sb.results_checked);
        $display("Status mix: ok %0d, too few operands %0d, count not one %0d, overflow %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_UNDERFLOW],
                 sb.status_seen[ST_NOT_ONE], sb.status_seen[ST_OVERFLOW]);
        if (sb.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
design/pse_pkg.sv
design/pse_cell.sv
design/pse_fg_unit.sv
design/postfix_stack_evaluator_unit.sv
sim/tb.sv
